>>> sv/rcfd_pkg.sv
// Package: shared types, codes and constants of the RC frame decoder.
package rcfd_pkg;

   localparam int FRAME_LEN  = 25;
   localparam int STORE_AW   = $clog2(FRAME_LEN);
   localparam int POS_W      = 6;
   localparam int POS_CW     = POS_W + 1;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam int CH_W       = 11;
   localparam int SUM_W      = 14;
   localparam int VAL_W      = 16;
   localparam int NUM_VALS   = 28;
   localparam int NUM_SBUS   = 16;
   localparam int NUM_CAL    = 4;

   localparam logic [1:0] PROTO_DBUS = 2'd1;
   localparam logic [1:0] PROTO_SBUS = 2'd2;
   localparam logic [1:0] PROTO_RESET = PROTO_SBUS;

   localparam logic [7:0] SBUS_HEADER = 8'h0F;

   // value_index codes
   localparam logic [4:0] IDX_SW1     = 5'd16;
   localparam logic [4:0] IDX_SW2     = 5'd17;
   localparam logic [4:0] IDX_MOUSE_X = 5'd18;
   localparam logic [4:0] IDX_MOUSE_Y = 5'd19;
   localparam logic [4:0] IDX_MOUSE_Z = 5'd20;
   localparam logic [4:0] IDX_BTN_L   = 5'd21;
   localparam logic [4:0] IDX_BTN_R   = 5'd22;
   localparam logic [4:0] IDX_KEY     = 5'd23;
   localparam logic [4:0] IDX_OFFSET0 = 5'd24;

   // items per run
   localparam logic [4:0] DBUS_CH_N = 5'd4;
   localparam logic [4:0] DBUS_N    = 5'd12;
   localparam logic [4:0] SBUS_N    = 5'd18;
   localparam logic [4:0] OFFS_N    = 5'd4;

   localparam logic [CH_W-1:0] SW_HIGH  = 11'd1500;
   localparam logic [CH_W-1:0] SW_LOW   = 11'd500;
   localparam logic [CH_W-1:0] WIN_LO   = 11'd900;
   localparam logic [CH_W-1:0] WIN_HI   = 11'd1200;
   localparam logic [11:0]     RANGE_HI = 12'd2500;
   localparam logic [CH_W-1:0] RANGE_LO = 11'd100;

   localparam logic [3:0] CAL_SAMPLES = 4'd10;
   localparam logic [4:0] FAIL_LIMIT  = 5'd30;

   // x / 10 == (x * 6554) >> 16, exact for x below 2**14
   localparam logic [12:0] DIV10_MUL   = 13'd6554;
   localparam int          DIV10_SHIFT = 16;

   localparam logic [1:0] SW_1 = 2'd1;
   localparam logic [1:0] SW_2 = 2'd2;
   localparam logic [1:0] SW_3 = 2'd3;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_CALIB   = 3'd2,
      ST_REJECT  = 3'd3,
      ST_DONE    = 3'd4,
      ST_DROP    = 3'd5,
      ST_FATAL   = 3'd6,
      ST_UNKNOWN = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_DBUS,
      KIND_SBUS
   } kind_type;

   typedef logic [FRAME_LEN-1:0][7:0] store_type;

   // decoded frame handed from the decoder to the result sequencer
   typedef struct packed {
      kind_type                         kind;
      logic                             with_offs;
      status_type                       status;
      logic [VAL_W-1:0]                 count;
      logic [NUM_VALS-1:0][VAL_W-1:0]   vals;
   } rec_type;

   typedef struct packed {
      logic [4:0]        value_index;
      logic [VAL_W-1:0]  value;
      logic              has_value;
      status_type        status;
      logic [VAL_W-1:0]  count;
      logic              last;
   } item_type;

endpackage

>>> sv/rcfd_if.sv
// Interfaces: byte input, result output and configuration channels.
interface rcfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface rcfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         value_index;
   logic signed [15:0] value;
   logic               has_value;
   logic [2:0]         frame_status;
   logic [15:0]        frame_count;
   logic               last_of_run;

   modport source (output valid, output value_index, output value, output has_value,
                   output frame_status, output frame_count, output last_of_run,
                   input ready);
   modport sink (input valid, input value_index, input value, input has_value,
                 input frame_status, input frame_count, input last_of_run,
                 output ready);
endinterface

interface rcfd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] protocol_type;

   modport source (output valid, output protocol_type, input ready);
   modport sink (input valid, input protocol_type, output ready);
endinterface

>>> sv/rcfd_collect.sv
// Byte collector: frame store, byte position and end-of-frame pending flag.
module rcfd_collect
   import rcfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rcfd_req_if.sink   req_bus,
   input  logic       fire,
   output store_type  store,
   output logic       pend
);

   store_type         store_ff, store_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              pend_ff, pend_in;
   logic              acc;

   // while a frame waits for decode, pos is already zero
   assign req_bus.ready = !pend_ff || fire;
   assign acc = req_bus.valid && req_bus.ready;
   assign store = store_ff;
   assign pend = pend_ff;

   always_comb begin
      store_in = fire ? '0 : store_ff;
      pos_in   = pos_ff;
      pend_in  = fire ? 1'b0 : pend_ff;
      if (acc) begin
         if ({1'b0, pos_ff} < POS_CW'(FRAME_LEN)) begin
            store_in[pos_ff[STORE_AW-1:0]] = req_bus.data_byte;
         end
         if (req_bus.frame_end) begin
            pos_in  = '0;
            pend_in = 1'b1;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         pos_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         store_ff <= store_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

>>> sv/rcfd_calib.sv
// Frame decoder with calibration state, counters and the protocol register.
module rcfd_calib
   import rcfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rcfd_csr_if.sink   csr_bus,
   input  logic       fire,
   input  store_type  store,
   output rec_type    rec
);

   logic [1:0]                  proto_ff;
   logic                        phase_ff, phase_in;
   logic [3:0]                  samples_ff, samples_in, samples_new;
   logic [NUM_CAL-1:0][SUM_W-1:0] sums_ff, sums_in, sums_new;
   logic [4:0]                  fail_ff, fail_in;
   logic [VAL_W-1:0]            good_ff, good_in;

   logic [NUM_SBUS-1:0][CH_W-1:0] sch;
   logic [NUM_CAL-1:0][CH_W-1:0]  dch, ch, offs;
   logic [1:0]                  dsw1, dsw2, ssw1, ssw2, sw1, sw2;
   logic                        is_dbus, is_sbus, hdr_ok, win, range_bad, clear;
   logic [NUM_VALS-1:0][VAL_W-1:0] vals;
   status_type                  st;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         proto_ff <= PROTO_RESET;
      end else if (csr_bus.valid) begin
         proto_ff <= csr_bus.protocol_type;
      end
   end

   assign is_dbus = (proto_ff == PROTO_DBUS);
   assign is_sbus = (proto_ff == PROTO_SBUS);
   assign hdr_ok  = (store[0] == SBUS_HEADER) && (store[FRAME_LEN-1] == 8'd0) &&
                    (store[FRAME_LEN-2] == 8'd0);

   // SBUS: sixteen 11-bit channels packed LSB first from byte 1
   for (genvar n = 0; n < NUM_SBUS; n++) begin : g_sbus
      localparam int BitPos  = n * CH_W;
      localparam int ByteIdx = 1 + BitPos / 8;
      localparam int Shift   = BitPos % 8;
      logic [23:0] span;
      assign span   = {store[ByteIdx+2], store[ByteIdx+1], store[ByteIdx]};
      assign sch[n] = span[Shift +: CH_W];
   end

   assign dch[0] = {store[1][2:0], store[0]};
   assign dch[1] = {store[2][5:0], store[1][7:3]};
   assign dch[2] = {store[4][0], store[3], store[2][7:6]};
   assign dch[3] = {store[5][3:0], store[4][7:1]};
   assign dsw1   = store[5][7:6];
   assign dsw2   = store[5][5:4];

   assign ssw1 = (sch[6] > SW_HIGH) ? SW_3 : (sch[6] < SW_LOW) ? SW_1 : SW_2;
   assign ssw2 = (sch[4] > SW_HIGH) ? SW_2 : (sch[4] < SW_LOW) ? SW_1 : SW_3;

   assign sw1 = is_dbus ? dsw1 : ssw1;
   assign sw2 = is_dbus ? dsw2 : ssw2;

   always_comb begin
      win = 1'b1;
      for (int i = 0; i < NUM_CAL; i++) begin
         ch[i] = is_dbus ? dch[i] : sch[i];
         if (ch[i] < WIN_LO || ch[i] > WIN_HI) begin
            win = 1'b0;
         end
      end
      range_bad = (sw1 == 2'd0) || (sw2 == 2'd0);
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, ch[i]} > RANGE_HI || ch[i] < RANGE_LO) begin
            range_bad = 1'b1;
         end
      end
   end

   // running sums and the averages (divide by ten via reciprocal)
   assign samples_new = samples_ff + 4'd1;
   always_comb begin
      for (int i = 0; i < NUM_CAL; i++) begin
         logic [26:0] prod;
         sums_new[i] = ((samples_ff == 4'd0) ? SUM_W'(0) : sums_ff[i]) + SUM_W'(ch[i]);
         prod        = 27'(sums_new[i]) * 27'(DIV10_MUL);
         offs[i]     = prod[DIV10_SHIFT +: CH_W];
      end
   end

   always_comb begin
      vals = '0;
      if (is_dbus) begin
         for (int i = 0; i < NUM_CAL; i++) begin
            vals[i] = VAL_W'(dch[i]);
         end
         vals[IDX_SW1]     = VAL_W'(dsw1);
         vals[IDX_SW2]     = VAL_W'(dsw2);
         vals[IDX_MOUSE_X] = {store[7], store[6]};
         vals[IDX_MOUSE_Y] = {store[9], store[8]};
         vals[IDX_MOUSE_Z] = {store[11], store[10]};
         vals[IDX_BTN_L]   = VAL_W'(store[12]);
         vals[IDX_BTN_R]   = VAL_W'(store[13]);
         vals[IDX_KEY]     = VAL_W'(store[14]);
      end else begin
         for (int i = 0; i < NUM_SBUS; i++) begin
            vals[i] = VAL_W'(sch[i]);
         end
         vals[IDX_SW1] = VAL_W'(ssw1);
         vals[IDX_SW2] = VAL_W'(ssw2);
      end
      for (int i = 0; i < NUM_CAL; i++) begin
         vals[IDX_OFFSET0 + 5'(i)] = VAL_W'(offs[i]);
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      samples_in = samples_ff;
      sums_in    = sums_ff;
      fail_in    = fail_ff;
      good_in    = good_ff;
      clear      = 1'b0;
      st         = ST_UNKNOWN;
      rec        = '0;
      rec.kind   = KIND_SINGLE;
      if (!is_dbus && !is_sbus) begin
         st = ST_UNKNOWN;
      end else if (is_sbus && !hdr_ok) begin
         if (!phase_ff) begin
            clear = 1'b1;
         end
         st = ST_DROP;
      end else begin
         rec.kind = is_dbus ? KIND_DBUS : KIND_SBUS;
         rec.vals = vals;
         if (!phase_ff) begin
            if (win) begin
               sums_in    = sums_new;
               samples_in = samples_new;
               good_in    = VAL_W'(samples_new);
               st         = (samples_new >= CAL_SAMPLES) ? ST_DONE : ST_CALIB;
            end else begin
               st = ST_REJECT;
            end
            if (st == ST_DONE) begin
               rec.with_offs = 1'b1;
               phase_in      = 1'b1;
            end else begin
               fail_in = fail_ff + 5'd1;
               if (fail_ff >= FAIL_LIMIT) begin
                  clear = 1'b1;
               end
            end
         end else if (range_bad) begin
            st = ST_RANGE;
         end else begin
            st      = ST_OK;
            good_in = good_ff + VAL_W'(1);
         end
      end
      rec.status = st;
      rec.count  = good_in;
      if (clear) begin
         phase_in      = 1'b0;
         samples_in    = '0;
         sums_in       = '0;
         fail_in       = '0;
         good_in       = '0;
         rec           = '0;
         rec.kind      = KIND_SINGLE;
         rec.status    = ST_FATAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         samples_ff <= '0;
         sums_ff    <= '0;
         fail_ff    <= '0;
         good_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         samples_ff <= samples_in;
         sums_ff    <= sums_in;
         fail_ff    <= fail_in;
         good_ff    <= good_in;
      end
   end

endmodule

>>> sv/rcfd_emit.sv
// Result sequencer: holds one decoded frame and steps its items into the output register.
module rcfd_emit
   import rcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  rec_type     rec,
   output logic        free,
   rcfd_rsp_if.source  rsp_bus
);

   rec_type     rec_ff;
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  num, idx;
   logic        adv, last;
   item_type    item, out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   always_comb begin
      case (rec_ff.kind)
         KIND_DBUS: begin
            num = rec_ff.with_offs ? DBUS_N + OFFS_N : DBUS_N;
            idx = (cnt_ff < DBUS_CH_N) ? cnt_ff : cnt_ff + (IDX_SW1 - DBUS_CH_N);
         end
         KIND_SBUS: begin
            num = rec_ff.with_offs ? SBUS_N + OFFS_N : SBUS_N;
            idx = (cnt_ff < SBUS_N) ? cnt_ff : cnt_ff + (IDX_OFFSET0 - SBUS_N);
         end
         default: begin
            num = 5'd1;
            idx = 5'd0;
         end
      endcase
   end

   assign last = (cnt_ff == num - 5'd1);
   assign adv  = busy_ff && (!out_valid_ff || rsp_bus.ready);
   assign free = !busy_ff || (adv && last);

   always_comb begin
      item.has_value   = (rec_ff.kind != KIND_SINGLE);
      item.value_index = item.has_value ? idx : 5'd0;
      item.value       = item.has_value ? rec_ff.vals[idx] : '0;
      item.status      = rec_ff.status;
      item.count       = rec_ff.count;
      item.last        = last;
   end

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (adv) begin
         out_in       = item;
         out_valid_in = 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
      if (load) begin
         rec_ff <= rec;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.value_index  = out_ff.value_index;
   assign rsp_bus.value        = $signed(out_ff.value);
   assign rsp_bus.has_value    = out_ff.has_value;
   assign rsp_bus.frame_status = out_ff.status;
   assign rsp_bus.frame_count  = out_ff.count;
   assign rsp_bus.last_of_run  = out_ff.last;

`ifndef SYNTH
   a_no_value_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.has_value) |-> out_ff.last)
      else $error("item without value is not the last of its run");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.has_value) |-> (out_ff.value_index <= 5'd27))
      else $error("value_index beyond 27");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff < num))
      else $error("item counter past end of run");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !busy_ff))
      else $error("sequencer not empty after reset");
`endif

endmodule

>>> sv/rc_frame_decode_calibrate.sv
// Top level: RC frame decoder with stick calibration (SBUS / DBUS).
//
//   channel   dir  payload                                         transfer
//   req_bus   in   data_byte, frame_end                            valid & ready
//   rsp_bus   out  value_index, value, has_value, frame_status,    valid & ready
//                  frame_count, last_of_run
//   csr_bus   in   protocol_type                                   valid & ready
//
// A byte is taken every cycle while req_bus.ready is high; a frame_end byte is decoded
// once it is in the frame store and the sequencer is free. Results leave one per cycle
// while rsp_bus.ready is high, from an output register. A frame gives 1, 12, 16, 18 or
// 22 results. The next frame_end byte is decoded only once the sequencer has sent the
// previous run, so req_bus.ready drops for that wait. Synchronous reset clears all
// state but the sequencer's held frame and output item; protocol_type returns to SBUS.
module rc_frame_decode_calibrate
   import rcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rcfd_req_if.sink    req_bus,
   rcfd_rsp_if.source  rsp_bus,
   rcfd_csr_if.sink    csr_bus
);

   store_type  store;
   rec_type    rec;
   logic       pend, free, fire;

   assign fire = pend && free;

   rcfd_collect u_collect (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .fire    (fire),
      .store   (store),
      .pend    (pend)
   );

   rcfd_calib u_calib (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .fire    (fire),
      .store   (store),
      .rec     (rec)
   );

   rcfd_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .load    (fire),
      .rec     (rec),
      .free    (free),
      .rsp_bus (rsp_bus)
   );

endmodule
